// ----- rtl/core/pedd_pkg.sv -----
`default_nettype none

package pedd_pkg;

    // Sizes of the stores.
    localparam int MAX_WIDTH     = 1024;
    localparam int PALETTE_DEPTH = 16;
    localparam int COL_W         = $clog2(MAX_WIDTH);
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

    // Starting distance of the nearest-colour search.
    localparam logic [17:0] START_DISTANCE = 18'd200000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROW_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_ROW_COUNT  = 2'd1;
    localparam logic [1:0] CFG_INDEX_BITS = 2'd2;
    localparam logic [1:0] CFG_DIFFUSE    = 2'd3;

    // Input item kinds.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    typedef struct packed {
        logic       func;
        logic [3:0] entry;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_t;

    typedef struct packed {
        logic [3:0] index;
        logic       frame_end;
    } out_t;

    typedef struct packed {
        logic [10:0] row_width;
        logic [15:0] row_count;
        logic [2:0]  index_bits;
        logic        diffuse;
    } cfg_t;

    // A queued item with its classification.
    typedef struct packed {
        logic is_pixel;
        logic load_ok;
        in_t  data;
    } qitem_t;

    // Status from the back end to the front end.
    typedef struct packed {
        logic clearing;
    } stat_t;

    // Channel 0 is red, 1 green, 2 blue.
    typedef logic [2:0][7:0] rgb_t;

    // Shares kept for one channel of one column of the next row.
    typedef struct packed {
        logic signed [4:0] s1;
        logic signed [6:0] s4;
        logic signed [5:0] s2;
    } share_t;

    typedef share_t [2:0] shares_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADJ,
        ST_SEARCH,
        ST_ERR,
        ST_RD1,
        ST_WR1,
        ST_DONE
    } state_t;

    // Clamp to the 0..255 pixel range.
    function automatic logic [7:0] clamp8(input logic signed [9:0] v);
        logic [7:0] r;
        if (v < 0)
            r = 8'd0;
        else if (v > 10'sd255)
            r = 8'd255;
        else
            r = v[7:0];
        return r;
    endfunction

    // Divide by sixteen, truncating toward zero.
    function automatic logic signed [12:0] div16(input logic signed [12:0] x);
        logic signed [12:0] r;
        if (x < 0)
            r = -((-x) >>> 4);
        else
            r = x >>> 4;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pedd_front.sv -----
`default_nettype none

module pedd_front
    import pedd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire in_t    in_data,
    input  wire stat_t  stat,
    output logic        q_valid,
    output qitem_t      q_item,
    input  wire logic   q_pop
);

    qitem_t     slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    qitem_t     cls;

    // Classify the incoming transaction.
    always_comb
    begin
        cls.is_pixel = (in_data.func == FUNC_PIXEL);
        cls.load_ok  = (32'(in_data.entry) < PALETTE_DEPTH);
        cls.data     = in_data;
    end

    assign in_ready = (count_reg != 2'd2) && !stat.clearing;
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    // Queue pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cls;
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");
    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> !push)
        else $error("transaction taken during clearing pass");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/pedd_back.sv -----
`default_nettype none

module pedd_back
    import pedd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   q_valid,
    input  wire qitem_t q_item,
    output logic        q_pop,
    output stat_t       stat,
    output logic        out_valid,
    input  wire logic   out_ready,
    output out_t        out_data
);

    state_t             state_reg, state_next;
    logic [COL_W-1:0]   clr_cnt_reg;
    logic [COL_W-1:0]   column_reg;
    logic [15:0]        row_reg;
    rgb_t               px_reg;
    rgb_t               best_col_reg;
    logic [PAL_AW-1:0]  best_idx_reg;
    logic [17:0]        bestd_reg;
    logic [PAL_AW-1:0]  srch_cnt_reg;
    logic signed [7:0]  right_reg [3];
    logic signed [4:0]  pend_reg [3];
    logic signed [5:0]  s2_reg [3];
    logic               out_valid_reg;
    out_t               out_reg;

    rgb_t               palette [PALETTE_DEPTH];
    shares_t            below_mem [MAX_WIDTH];
    shares_t            rd_data_reg;

    logic               mem_we;
    logic [COL_W-1:0]   mem_addr;
    shares_t            mem_wdata;
    logic               out_free;
    logic               out_load;

    logic [10:0]        w_eff;
    logic [15:0]        h_eff;
    logic               last_col;
    logic               last_row;
    logic [PAL_AW-1:0]  search_last;

    rgb_t               adj_px;
    rgb_t               pal_rd;
    logic [17:0]        pal_dist;
    logic signed [8:0]  diff [3];
    logic signed [17:0] sq [3];

    logic signed [9:0]  err [3];
    logic signed [12:0] err_x [3];
    logic signed [7:0]  s7 [3];
    logic signed [6:0]  s4 [3];
    logic signed [5:0]  s2 [3];
    logic signed [4:0]  s1 [3];
    shares_t            err_wdata;
    shares_t            fix_wdata;

    // Effective frame bounds and position flags.
    always_comb
    begin
        if (cfg.row_width == 11'd0)
            w_eff = 11'd1;
        else if (cfg.row_width > 11'(MAX_WIDTH))
            w_eff = 11'(MAX_WIDTH);
        else
            w_eff = cfg.row_width;
        h_eff    = (cfg.row_count == 16'd0) ? 16'd1 : cfg.row_count;
        last_col = 11'(column_reg) >= (w_eff - 11'd1);
        last_row = row_reg >= (h_eff - 16'd1);
        if (cfg.index_bits >= 3'(PAL_AW))
            search_last = PAL_AW'(PALETTE_DEPTH - 1);
        else
            search_last = PAL_AW'((9'd1 << cfg.index_bits) - 9'd1);
    end

    // Pixel adjusted, when diffusion is on, by the shares from the row above and from the left.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [7:0] v;
            v = px_reg[c];
            v = clamp8(signed'({2'b00, v}) + 10'(rd_data_reg[c].s1));
            v = clamp8(signed'({2'b00, v}) + 10'(rd_data_reg[c].s4));
            v = clamp8(signed'({2'b00, v}) + 10'(rd_data_reg[c].s2));
            v = clamp8(signed'({2'b00, v}) + 10'(right_reg[c]));
            adj_px[c] = cfg.diffuse ? v : px_reg[c];
        end
    end

    // Distance to the palette entry under search.
    always_comb
    begin
        pal_rd   = palette[srch_cnt_reg];
        pal_dist = 18'd0;
        for (int c = 0; c < 3; c++)
        begin
            diff[c]  = signed'({1'b0, pal_rd[c]}) - signed'({1'b0, px_reg[c]});
            sq[c]    = diff[c] * diff[c];
            pal_dist = pal_dist + 18'(unsigned'(sq[c]));
        end
    end

    // Error shares of the finished pixel.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            err[c]   = cfg.diffuse
                       ? signed'({2'b00, px_reg[c]}) - signed'({2'b00, best_col_reg[c]})
                       : 10'sd0;
            err_x[c] = 13'(err[c]);
            s7[c] = last_col ? 8'sd0 : 8'(div16(err_x[c] * 13'sd7));
            s4[c] = last_row ? 7'sd0 : 7'(div16(err_x[c] * 13'sd4));
            s2[c] = last_row ? 6'sd0 : 6'(div16(err_x[c] * 13'sd2));
            s1[c] = (last_row || last_col) ? 5'sd0 : 5'(div16(err_x[c]));
            err_wdata[c].s1 = pend_reg[c];
            err_wdata[c].s4 = s4[c];
            err_wdata[c].s2 = 6'sd0;
            fix_wdata[c]    = rd_data_reg[c];
            fix_wdata[c].s2 = s2_reg[c];
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == COL_W'(MAX_WIDTH - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (q_valid && q_item.is_pixel)
                    state_next = ST_ADJ;
            ST_ADJ:
                state_next = ST_SEARCH;
            ST_SEARCH:
                if (srch_cnt_reg == search_last)
                    state_next = ST_ERR;
            ST_ERR:
                state_next = (column_reg != '0) ? ST_RD1 : ST_DONE;
            ST_RD1:
                state_next = ST_WR1;
            ST_WR1:
                state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State outputs: queue pop, share memory port and output load.
    always_comb
    begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = column_reg;
        mem_wdata = '0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
            end
            ST_IDLE:
                q_pop = q_valid;
            ST_ERR:
            begin
                mem_we    = 1'b1;
                mem_wdata = err_wdata;
            end
            ST_RD1:
                mem_addr = column_reg - COL_W'(1);
            ST_WR1:
            begin
                mem_we    = 1'b1;
                mem_addr  = column_reg - COL_W'(1);
                mem_wdata = fix_wdata;
            end
            ST_DONE:
                out_load = out_free;
            default:
                q_pop = 1'b0;
        endcase
    end

    assign stat.clearing = (state_reg == ST_CLEAR);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            column_reg    <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                right_reg[c] <= '0;
                pend_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + COL_W'(1);
            if (state_reg == ST_ERR)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    right_reg[c] <= s7[c];
                    pend_reg[c]  <= s1[c];
                end
            end
            if (out_load)
            begin
                if (last_col)
                begin
                    column_reg <= '0;
                    row_reg    <= last_row ? 16'd0 : row_reg + 16'd1;
                end
                else
                    column_reg <= column_reg + COL_W'(1);
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && q_item.is_pixel)
            px_reg <= {q_item.data.blue, q_item.data.green, q_item.data.red};
        if (state_reg == ST_ADJ)
        begin
            px_reg       <= adj_px;
            srch_cnt_reg <= '0;
            bestd_reg    <= START_DISTANCE;
            best_idx_reg <= '0;
            best_col_reg <= '0;
        end
        if (state_reg == ST_SEARCH)
        begin
            srch_cnt_reg <= srch_cnt_reg + PAL_AW'(1);
            if (pal_dist < bestd_reg)
            begin
                bestd_reg    <= pal_dist;
                best_idx_reg <= srch_cnt_reg;
                best_col_reg <= pal_rd;
            end
        end
        if (state_reg == ST_ERR)
        begin
            for (int c = 0; c < 3; c++)
                s2_reg[c] <= s2[c];
        end
        if (out_load)
        begin
            out_reg.index     <= 4'(best_idx_reg);
            out_reg.frame_end <= last_col && last_row;
        end
    end

    // Palette store, loaded in stream order.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && !q_item.is_pixel && q_item.load_ok)
            palette[PAL_AW'(q_item.data.entry)] <=
                {q_item.data.blue, q_item.data.green, q_item.data.red};
    end

    // Share memory for the next row, one port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            below_mem[mem_addr] <= mem_wdata;
        else
            rd_data_reg <= below_mem[mem_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("queue popped while busy");
    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (srch_cnt_reg <= search_last))
        else $error("search ran past the last entry");
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_col) |=> (column_reg == '0))
        else $error("column did not wrap at row end");
    a_no_write_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> !mem_we)
        else $error("share memory written during search");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/palette_error_diffusion_dither_unit.sv -----
// A pixel passes the back end in order: popped in idle, adjusted, searched over the N
// palette entries at one entry per cycle, error step writing the shares, read and rewrite
// of the column to the left (skipped at column zero), then done until the output is free.
// A palette load is written from idle, no result; the queue takes up to two items while the
// back end works. Reset is asynchronous, active low; a clearing pass then zeroes the share
// memory, during which no transaction is accepted (configuration writes still are).
`default_nettype none

module palette_error_diffusion_dither_unit
    import pedd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_t             out_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t   cfg_reg;
    logic   q_valid;
    logic   q_pop;
    qitem_t q_item;
    stat_t  stat;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_width  <= 11'd16;
            cfg_reg.row_count  <= 16'd16;
            cfg_reg.index_bits <= 3'd4;
            cfg_reg.diffuse    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROW_WIDTH:  cfg_reg.row_width  <= cfg_data[10:0];
                CFG_ROW_COUNT:  cfg_reg.row_count  <= cfg_data;
                CFG_INDEX_BITS: cfg_reg.index_bits <= cfg_data[2:0];
                CFG_DIFFUSE:    cfg_reg.diffuse    <= cfg_data[0];
                default:        cfg_reg.diffuse    <= cfg_reg.diffuse;
            endcase
        end
    end

    pedd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .stat     (stat),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    pedd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
